/* rtl/core/lba_to_chs_converter_assert.svh */
// assertion macros for the lba to chs converter
`ifndef LBA_TO_CHS_CONVERTER_ASSERT_SVH
`define LBA_TO_CHS_CONVERTER_ASSERT_SVH

// same-cycle implication
`define LBAC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbac same-cycle check failed");

// next-cycle implication
`define LBAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbac next-cycle check failed");

`endif

/* rtl/core/lbac_pkg.sv */
// constants and register codes for the lba to chs converter
package lbac_pkg;

   localparam int HEADS_W  = 9;
   localparam int SPT_W    = 6;
   localparam int DRIVE_W  = 8;
   localparam int CYL_W    = 10;
   localparam int HEAD_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE = 2'd2;

   localparam logic [CMD_W-1:0] CMD_READ  = 16'h0201;
   localparam logic [CMD_W-1:0] CMD_WRITE = 16'h0301;

   localparam logic [DRIVE_W-1:0] DRIVE_RESET = 8'd128;
   localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;
   localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;

endpackage

/* rtl/core/lbac_div_cell.sv */
// one restoring division step cell, registered, passing its item to the next cell
module lbac_div_cell #(
   parameter int WORK_W = 24,
   parameter int DIV_W  = 6,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DIV_W-1:0]  divisor,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  in_rem,
   input  logic [WORK_W-1:0] in_work,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DIV_W-1:0]  out_rem,
   output logic [WORK_W-1:0] out_work,
   output logic [SIDE_W-1:0] out_side
);

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              take;
   logic              valid_ff;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [WORK_W-1:0] work_ff, work_in;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      trial   = {in_rem, in_work[WORK_W-1]};
      diff    = trial - {1'b0, divisor};
      take    = (trial >= {1'b0, divisor});
      rem_in  = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      work_in = {in_work[WORK_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/core/lba_to_chs_converter.sv */
// lba to chs converter top level: two division cell chains and the result register
//
// One item is taken every clock cycle while busy is low; each result passes through two
// rows of LBA_WIDTH restoring-division cells (one quotient bit per cell: first by
// sectors per track, then by heads) and one output register. The result is shown
// for a single cycle on rsp_strobe and cannot be held off. busy is high during reset
// and in the cycle after it. Geometry must be written only with no item in flight.
module lba_to_chs_converter
   import lbac_pkg::*;
#(
   parameter int LBA_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [LBA_WIDTH-1:0]  req_sector_index,
   output logic                  rsp_strobe,
   output logic [CYL_W-1:0]      rsp_cylinder,
   output logic [HEAD_W-1:0]     rsp_head,
   output logic [SPT_W-1:0]      rsp_sector,
   output logic [BYTE_W-1:0]     rsp_ch_byte,
   output logic [BYTE_W-1:0]     rsp_cl_byte,
   output logic [BYTE_W-1:0]     rsp_dh_byte,
   output logic [BYTE_W-1:0]     rsp_dl_byte,
   output logic [CMD_W-1:0]      rsp_command_word,
   output logic                  rsp_cylinder_overflow,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SIDE2_W = SPT_W + 1;

   logic                busy_ff;
   logic [HEADS_W-1:0]  heads_ff;
   logic [SPT_W-1:0]    sectors_ff;
   logic [DRIVE_W-1:0]  drive_ff;
   logic                accept;
   logic                csr_write;

   logic [LBA_WIDTH:0]   v1;
   logic [SPT_W-1:0]     rem1  [0:LBA_WIDTH];
   logic [LBA_WIDTH-1:0] work1 [0:LBA_WIDTH];
   logic                 side1 [0:LBA_WIDTH];

   logic [LBA_WIDTH:0]   v2;
   logic [HEADS_W-1:0]   rem2  [0:LBA_WIDTH];
   logic [LBA_WIDTH-1:0] work2 [0:LBA_WIDTH];
   logic [SIDE2_W-1:0]   side2 [0:LBA_WIDTH];

   logic                 strobe_ff;
   logic [CYL_W-1:0]     cyl_ff;
   logic [HEAD_W-1:0]    head_ff;
   logic [SPT_W-1:0]     sec_ff;
   logic                 op_ff;
   logic                 ovf_ff;
   logic [SPT_W-1:0]     sec_in;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         heads_ff   <= HEADS_RESET;
         sectors_ff <= SPT_RESET;
         drive_ff   <= DRIVE_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_HEADS: begin
                  heads_ff <= (csr_data[HEADS_W-1:0] == '0) ?
                              HEADS_W'(1) : csr_data[HEADS_W-1:0];
               end
               CSR_SPT: begin
                  sectors_ff <= (csr_data[SPT_W-1:0] == '0) ?
                                SPT_W'(1) : csr_data[SPT_W-1:0];
               end
               CSR_DRIVE: begin
                  drive_ff <= csr_data[DRIVE_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // first chain: sector index by sectors per track
   assign v1[0]    = accept;
   assign rem1[0]  = '0;
   assign work1[0] = req_sector_index;
   assign side1[0] = req_op;

   // second chain: track number by heads, carrying op and sector remainder
   assign v2[0]    = v1[LBA_WIDTH];
   assign rem2[0]  = '0;
   assign work2[0] = work1[LBA_WIDTH];
   assign side2[0] = {side1[LBA_WIDTH], rem1[LBA_WIDTH]};

   for (genvar i = 0; i < LBA_WIDTH; i++) begin : g_chain
      lbac_div_cell #(
         .WORK_W (LBA_WIDTH),
         .DIV_W  (SPT_W),
         .SIDE_W (1)
      ) u_spt_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (sectors_ff),
         .in_valid  (v1[i]),
         .in_rem    (rem1[i]),
         .in_work   (work1[i]),
         .in_side   (side1[i]),
         .out_valid (v1[i+1]),
         .out_rem   (rem1[i+1]),
         .out_work  (work1[i+1]),
         .out_side  (side1[i+1])
      );

      lbac_div_cell #(
         .WORK_W (LBA_WIDTH),
         .DIV_W  (HEADS_W),
         .SIDE_W (SIDE2_W)
      ) u_head_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (heads_ff),
         .in_valid  (v2[i]),
         .in_rem    (rem2[i]),
         .in_work   (work2[i]),
         .in_side   (side2[i]),
         .out_valid (v2[i+1]),
         .out_rem   (rem2[i+1]),
         .out_work  (work2[i+1]),
         .out_side  (side2[i+1])
      );
   end

   assign sec_in = side2[LBA_WIDTH][SPT_W-1:0] + SPT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v2[LBA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      cyl_ff  <= work2[LBA_WIDTH][CYL_W-1:0];
      ovf_ff  <= |work2[LBA_WIDTH][LBA_WIDTH-1:CYL_W];
      head_ff <= rem2[LBA_WIDTH][HEAD_W-1:0];
      sec_ff  <= sec_in;
      op_ff   <= side2[LBA_WIDTH][SPT_W];
   end

   assign busy                  = busy_ff;
   assign rsp_strobe            = strobe_ff;
   assign rsp_cylinder          = cyl_ff;
   assign rsp_head              = head_ff;
   assign rsp_sector            = sec_ff;
   assign rsp_ch_byte           = cyl_ff[BYTE_W-1:0];
   assign rsp_cl_byte           = {cyl_ff[CYL_W-1:BYTE_W], sec_ff};
   assign rsp_dh_byte           = head_ff;
   assign rsp_dl_byte           = drive_ff;
   assign rsp_command_word      = op_ff ? CMD_WRITE : CMD_READ;
   assign rsp_cylinder_overflow = ovf_ff;

`include "lba_to_chs_converter_assert.svh"

   `LBAC_ASSERT_NOW(a_sector_range, clock, reset, rsp_strobe,
      (rsp_sector != '0) && (rsp_sector <= sectors_ff))
   `LBAC_ASSERT_NOW(a_head_range, clock, reset, rsp_strobe,
      ({1'b0, rsp_head} < heads_ff))
   `LBAC_ASSERT_NOW(a_cmd_code, clock, reset, rsp_strobe,
      (rsp_command_word == CMD_READ) || (rsp_command_word == CMD_WRITE))
   `LBAC_ASSERT_NEXT(a_spt_write, clock, reset,
      csr_write && (csr_index == CSR_SPT) && (csr_data[SPT_W-1:0] != '0),
      sectors_ff == $past(csr_data[SPT_W-1:0]))

endmodule
